>>> rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/sv39ptw_pkg.sv
package sv39ptw_pkg;

    localparam int LEVELS        = 3;
    localparam int INDEX_BITS    = 9;
    localparam int VPN_W         = LEVELS * INDEX_BITS;
    localparam int LVL_W         = $clog2(LEVELS);
    localparam int PAGE_SHIFT    = 12;
    localparam int FRAME_W       = 44;
    localparam int ADDR_W        = 56;
    localparam int VA_W          = 39;
    localparam int PTE_W         = 64;
    localparam int FLAG_W        = 8;
    localparam int KIND_W        = 2;
    localparam int PTE_PPN_LSB   = 10;
    localparam int PTE_VALID_BIT = 0;
    localparam int ENTRY_SHIFT   = 3;

    localparam logic             ACT_START  = 1'b0;
    localparam logic             ACT_RESP   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAULT = 2'd2;

    localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(LEVELS - 1);

    typedef struct packed {
        logic              emit;
        logic              start;
        logic              advance;
        logic [KIND_W-1:0] kind;
        logic [LVL_W-1:0]  level;
    } t_ctl_cmd;

    typedef struct packed {
        logic pte_valid;
    } t_dp_sts;

endpackage

>>> rtl/core/sv39ptw_if.sv
interface sv39ptw_req_if import sv39ptw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [VA_W-1:0]  virt_addr;
    logic [PTE_W-1:0] pte_data;

    modport source (output valid, action, virt_addr, pte_data, input ready);
    modport sink   (input valid, action, virt_addr, pte_data, output ready);
endinterface

interface sv39ptw_rsp_if import sv39ptw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] mem_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic [FLAG_W-1:0] leaf_flags;

    modport source (output valid, kind, mem_addr, phys_addr, leaf_flags, input ready);
    modport sink   (input valid, kind, mem_addr, phys_addr, leaf_flags, output ready);
endinterface

>>> rtl/core/sv39ptw_ctrl.sv
`include "assert_macros.svh"

module sv39ptw_ctrl import sv39ptw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_action,
    input  logic     i_out_ready,
    input  t_dp_sts  i_sts,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_ctl_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic             r_state, n_state;
    logic [LVL_W-1:0] r_level, n_level;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             start_acc;
    logic             idle_resp;
    logic             idle_ok;
    logic             walk_busy;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_level       = r_level;
        o_cmd.emit    = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.advance = 1'b0;
        o_cmd.kind    = KIND_READ;
        o_cmd.level   = '0;
        if (accept && i_action == ACT_START) begin
            o_cmd.emit  = 1'b1;
            o_cmd.start = 1'b1;
            n_state     = ST_WALK;
            n_level     = '0;
        end else if (accept && r_state == ST_WALK) begin
            o_cmd.emit = 1'b1;
            if (r_level == LAST_LEVEL) begin
                o_cmd.kind = KIND_DONE;
                n_state    = ST_IDLE;
                n_level    = '0;
            end else if (!i_sts.pte_valid) begin
                o_cmd.kind = KIND_FAULT;
                n_state    = ST_IDLE;
                n_level    = '0;
            end else begin
                o_cmd.advance = 1'b1;
                o_cmd.level   = r_level + LVL_W'(1);
                n_level       = r_level + LVL_W'(1);
            end
        end
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    assign start_acc = accept && i_action == ACT_START;
    assign idle_resp = r_state == ST_IDLE && !r_out_valid && i_in_valid && i_action == ACT_RESP;
    assign idle_ok   = (r_state != ST_IDLE) || (r_level == '0);
    assign walk_busy = r_out_valid && r_state == ST_WALK;

    `ASSERT_ALWAYS(a_level_range, i_clk, i_rst_n, r_level <= LAST_LEVEL, "walk level out of range")
    `ASSERT_ALWAYS(a_idle_level, i_clk, i_rst_n, idle_ok, "idle with nonzero level")
    `ASSERT_NEXT(a_start_walk, i_clk, i_rst_n, start_acc, walk_busy, "no walk after start")
    `ASSERT_NEXT(a_idle_resp, i_clk, i_rst_n, idle_resp, !r_out_valid, "idle response gave a result")

endmodule

>>> rtl/core/sv39ptw_dp.sv
module sv39ptw_dp import sv39ptw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [FRAME_W-1:0] i_cfg_wr_data,
    input  logic [VA_W-1:0]    i_virt_addr,
    input  logic [PTE_W-1:0]   i_pte_data,
    input  t_ctl_cmd           i_cmd,
    output t_dp_sts            o_sts,
    output logic [KIND_W-1:0]  o_kind,
    output logic [ADDR_W-1:0]  o_mem_addr,
    output logic [ADDR_W-1:0]  o_phys_addr,
    output logic [FLAG_W-1:0]  o_leaf_flags
);

    function automatic logic [INDEX_BITS-1:0] level_index(
        input logic [VPN_W-1:0] pn,
        input logic [LVL_W-1:0] lvl
    );
        logic [INDEX_BITS-1:0] idx;
        idx = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (lvl == LVL_W'(l)) begin
                idx = pn[(LEVELS - 1 - l) * INDEX_BITS +: INDEX_BITS];
            end
        end
        return idx;
    endfunction

    logic [FRAME_W-1:0]    r_root;
    logic [VPN_W-1:0]      r_page_number;
    logic [PAGE_SHIFT-1:0] r_page_offset;
    logic [KIND_W-1:0]     r_kind;
    logic [ADDR_W-1:0]     r_mem_addr;
    logic [ADDR_W-1:0]     r_phys_addr;
    logic [FLAG_W-1:0]     r_flags;

    logic [PTE_W-1:0]      va_ext;
    logic [VPN_W-1:0]      va_vpn;
    logic [FRAME_W-1:0]    pte_ppn;
    logic [FRAME_W-1:0]    frame_sel;
    logic [VPN_W-1:0]      vpn_sel;
    logic [ADDR_W-1:0]     entry_addr;

    assign va_ext          = PTE_W'(i_virt_addr);
    assign va_vpn          = va_ext[PAGE_SHIFT +: VPN_W];
    assign pte_ppn         = i_pte_data[PTE_PPN_LSB +: FRAME_W];
    assign o_sts.pte_valid = i_pte_data[PTE_VALID_BIT];

    assign frame_sel  = i_cmd.start ? r_root : pte_ppn;
    assign vpn_sel    = i_cmd.start ? va_vpn : r_page_number;
    assign entry_addr = (ADDR_W'(frame_sel) << PAGE_SHIFT)
                      | (ADDR_W'(level_index(vpn_sel, i_cmd.level)) << ENTRY_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_wr_en) begin
            r_root <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page_number <= va_vpn;
            r_page_offset <= i_virt_addr[PAGE_SHIFT-1:0];
        end
        if (i_cmd.emit) begin
            r_kind      <= i_cmd.kind;
            r_mem_addr  <= '0;
            r_phys_addr <= '0;
            r_flags     <= '0;
            case (i_cmd.kind)
                KIND_READ: begin
                    r_mem_addr <= entry_addr;
                end
                KIND_DONE: begin
                    r_phys_addr <= {pte_ppn, r_page_offset};
                    r_flags     <= i_pte_data[FLAG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_kind       = r_kind;
    assign o_mem_addr   = r_mem_addr;
    assign o_phys_addr  = r_phys_addr;
    assign o_leaf_flags = r_flags;

endmodule

>>> rtl/core/sv39_page_table_walker_core.sv
// Sv39 page table walker. A start transfer (action 0) latches the virtual address and returns
// a read request for the top-level entry in the root frame; each response transfer
// (action 1) returns either the next read request, a page fault (valid bit clear above the
// last level) or the finished translation with the leaf flag byte. Responses while no walk
// is active are dropped, and a start during a walk restarts it. Every item is handled by the
// controller and a single address datapath; its result sits in the output register from the
// next cycle, so one item per cycle is taken whenever the output side keeps up, and input
// ready falls only while the output register holds an untaken result. The user must write the
// root frame register only while idle, via the configuration port; the block does not check.
module sv39_page_table_walker_core import sv39ptw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [FRAME_W-1:0] i_cfg_wr_data,
    sv39ptw_req_if.sink        i_req,
    sv39ptw_rsp_if.source      o_rsp
);

    t_ctl_cmd cmd;
    t_dp_sts  sts;

    sv39ptw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_action    (i_req.action),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    sv39ptw_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_virt_addr   (i_req.virt_addr),
        .i_pte_data    (i_req.pte_data),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_kind        (o_rsp.kind),
        .o_mem_addr    (o_rsp.mem_addr),
        .o_phys_addr   (o_rsp.phys_addr),
        .o_leaf_flags  (o_rsp.leaf_flags)
    );

endmodule
